FILE: rtl/ptat_pkg.sv
// Package: shared types, codes and decode functions for the page table translation block
package ptat_pkg;

    // Default table depth and fixed field widths
    localparam int ENTRY_COUNT_DEFAULT = 512;
    localparam int IDX_W   = 9;
    localparam int WOFF_W  = 23;
    localparam int LADDR_W = 25;
    localparam int PADDR_W = 24;

    // Item operation codes
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    // Processor mode codes (the unused code behaves as user)
    localparam logic [1:0] MODE_USER       = 2'd0;
    localparam logic [1:0] MODE_OS         = 2'd1;
    localparam logic [1:0] MODE_SUPERVISOR = 2'd2;

    // Page size codes
    localparam logic [1:0] PAGE_4K  = 2'd0;
    localparam logic [1:0] PAGE_8K  = 2'd1;
    localparam logic [1:0] PAGE_16K = 2'd2;
    localparam logic [1:0] PAGE_32K = 2'd3;

    // Protection level codes
    localparam logic [1:0] PROT_OPEN     = 2'd0;
    localparam logic [1:0] PROT_READ_ALL = 2'd1;

    // Item travelling down the cell chain; ent carries the write data for a
    // write item and the matching entry for a translate item that has hit
    typedef struct packed {
        logic               op;
        logic [LADDR_W-1:0] laddr;
        logic [1:0]         mode;
        logic               wr;
        logic               hit;
        logic [WOFF_W-1:0]  ent;
    } ptat_token_t;

    // Mask on entry/address bits 22..12 for the given page size
    function automatic logic [10:0] field_mask(input logic [1:0] sz);
        logic [10:0] m;
        unique case (sz)
            PAGE_4K:  m = 11'h7ff;
            PAGE_8K:  m = 11'h7fe;
            PAGE_16K: m = 11'h7fc;
            PAGE_32K: m = 11'h7f8;
            default:  m = 11'h7ff;
        endcase
        return m;
    endfunction

    // Unscramble the physical page number from the low entry bits
    function automatic logic [8:0] phys_page(input logic [WOFF_W-1:0] e,
                                             input logic [1:0] sz);
        logic [8:0] p;
        unique case (sz)
            PAGE_4K:  p = {2'b00, e[6:0]};
            PAGE_8K:  p = {2'b00, e[0], e[6:1]};
            PAGE_16K: p = {2'b00, e[1:0], e[6:2]};
            PAGE_32K: p = {e[12], e[7], e[1], e[2], e[0], e[6:3]};
            default:  p = {2'b00, e[6:0]};
        endcase
        return p;
    endfunction

    // Build the physical byte address from the page number and page offset
    function automatic logic [PADDR_W-1:0] phys_addr(input logic [WOFF_W-1:0] e,
                                                     input logic [1:0] sz,
                                                     input logic [LADDR_W-1:0] la);
        logic [8:0]         p;
        logic [PADDR_W-1:0] a;
        p = phys_page(e, sz);
        unique case (sz)
            PAGE_4K:  a = {5'b0, p[6:0], la[11:0]};
            PAGE_8K:  a = {4'b0, p[6:0], la[12:0]};
            PAGE_16K: a = {3'b0, p[6:0], la[13:0]};
            PAGE_32K: a = {p[8:0], la[14:0]};
            default:  a = {5'b0, p[6:0], la[11:0]};
        endcase
        return a;
    endfunction

    // Decode the protection level against mode and direction
    function automatic logic perm_check(input logic [1:0] level,
                                        input logic [1:0] mode,
                                        input logic wr);
        logic priv;
        logic svc;
        logic ok;
        priv = (mode == MODE_OS) || (mode == MODE_SUPERVISOR);
        svc  = (mode == MODE_SUPERVISOR);
        priority if (level == PROT_OPEN)
            ok = 1'b1;
        else if (level == PROT_READ_ALL)
            ok = wr ? priv : 1'b1;
        else
            ok = wr ? svc : priv;
        return ok;
    endfunction

endpackage

FILE: rtl/ptat_cell.sv
// Module: one page table cell holding one entry and one chain stage
module ptat_cell
    import ptat_pkg::*;
#(
    parameter int CELL_INDEX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [1:0]  page_size,
    input  logic        tok_in_valid,
    input  ptat_token_t tok_in,
    output logic        tok_out_valid,
    output ptat_token_t tok_out
);

    logic [WOFF_W-1:0] entry_reg;
    logic              tok_valid_reg;
    ptat_token_t       tok_reg;
    ptat_token_t       tok_next;
    logic [IDX_W-1:0]  wr_idx;
    logic              wr_here;
    logic              match;
    logic [10:0]       mask;

    // Decode write index and compare the incoming item against this entry
    always_comb
    begin
        mask    = field_mask(page_size);
        wr_idx  = {tok_in.ent[12], tok_in.ent[7:0]};
        wr_here = tok_in_valid && (tok_in.op == OP_WRITE) &&
                  (wr_idx == IDX_W'(CELL_INDEX));
        match   = (entry_reg != '0) &&
                  (tok_in.laddr[24:23] == entry_reg[11:10]) &&
                  ((tok_in.laddr[22:12] & mask) == (entry_reg[22:12] & mask));
        tok_next = tok_in;
        if (tok_in_valid && (tok_in.op == OP_TRANSLATE) && !tok_in.hit && match)
        begin
            tok_next.hit = 1'b1;
            tok_next.ent = entry_reg;
        end
    end

    // Store the entry when a write item for this index passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else if (advance && wr_here)
            entry_reg <= tok_in.ent;
    end

    // Advance the chain stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else if (advance)
            tok_valid_reg <= tok_in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            tok_reg <= tok_next;
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

    // A write item never picks up a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid_reg && tok_reg.hit |-> tok_reg.op == OP_TRANSLATE)
        else $error("write item carries a hit");

    // A hit always carries a valid (non-zero) entry
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid_reg && tok_reg.hit |-> tok_reg.ent != '0)
        else $error("hit on an invalid entry");

    // A stalled stage holds its item
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance && tok_valid_reg |=> tok_valid_reg && $stable(tok_reg))
        else $error("stage changed while stalled");

endmodule

FILE: rtl/ptat_result.sv
// Module: output register forming hit, permission and physical address
module ptat_result
    import ptat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         page_size,
    input  logic               tok_valid,
    input  ptat_token_t        tok,
    output logic               advance,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic               permitted,
    output logic [PADDR_W-1:0] physical_address
);

    logic               out_valid_reg;
    logic               hit_reg;
    logic               perm_reg;
    logic [PADDR_W-1:0] paddr_reg;
    logic               perm_next;
    logic [PADDR_W-1:0] paddr_next;

    // Move the chain whenever the output register is free or being emptied
    assign advance = !out_valid_reg || out_ready;

    // Decode the result of the chain's last item
    always_comb
    begin
        perm_next  = 1'b0;
        paddr_next = '0;
        if (tok.hit)
        begin
            perm_next  = perm_check(tok.ent[9:8], tok.mode, tok.wr);
            paddr_next = phys_addr(tok.ent, page_size, tok.laddr);
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= tok_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && tok_valid)
        begin
            hit_reg   <= tok.hit;
            perm_reg  <= perm_next;
            paddr_reg <= paddr_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign hit              = hit_reg;
    assign permitted        = perm_reg;
    assign physical_address = paddr_reg;

    // A miss reports no permission and a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hit_reg |-> !perm_reg && (paddr_reg == '0))
        else $error("miss with non-zero result");

    // A blocked result stays in place and the chain stops behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(paddr_reg))
        else $error("result lost while stalled");

    // The chain only moves when the output register can take its item
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !out_valid_reg || out_ready)
        else $error("chain moved into a full output register");

endmodule

FILE: rtl/page_table_address_translation.sv
// Top level: page table translation built as a chain of entry cells
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: op selects a table
//   write (entry index and value from page_write_offset) or a translation of
//   logical_address for access_mode and is_write. Every item yields exactly
//   one result on the output channel (out_valid/out_ready): hit, permitted
//   and physical_address, all zero for a write or a miss. When several
//   entries match, the lowest index wins.
//   The page size register is loaded from cfg_write_data when cfg_write_en
//   is high; change it only while no item is in flight.
// Timing:
//   An item is taken into the first of ENTRY_COUNT cells at its accepting
//   edge and moves one cell per cycle, while the output is not stalled,
//   through the row into the output register. Items follow each other, one
//   per cycle while the output is not stalled; writes and translations keep
//   their order. Reset and stalls:
//   Reset clears every entry to invalid and the page size to 4K at once.
//   While the output register holds an untaken result, the whole row and
//   the input channel stop; nothing is dropped.
module page_table_address_translation
    import ptat_pkg::*;
#(
    parameter int ENTRY_COUNT = ENTRY_COUNT_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_write_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [WOFF_W-1:0]  page_write_offset,
    input  logic [LADDR_W-1:0] logical_address,
    input  logic [1:0]         access_mode,
    input  logic               is_write,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic               permitted,
    output logic [PADDR_W-1:0] physical_address
);

    logic        in_accept;
    logic [1:0]  page_size_reg;
    logic        advance;
    logic        chain_valid [0:ENTRY_COUNT];
    ptat_token_t chain_tok   [0:ENTRY_COUNT];

    // Hold the page size setting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            page_size_reg <= PAGE_4K;
        else if (cfg_write_en)
            page_size_reg <= cfg_write_data;
    end

    // Flag an accepted item for the head of the row
    assign in_accept      = in_valid && advance;
    assign chain_valid[0] = in_accept;

    // Form the item entering the first cell
    assign chain_tok[0] = {op, logical_address, access_mode, is_write, 1'b0,
                           (op == OP_WRITE) ? page_write_offset : {WOFF_W{1'b0}}};

    assign in_ready = advance;

    // Row of entry cells
    for (genvar g = 0; g < ENTRY_COUNT; g++)
    begin : g_cell
        ptat_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .advance       (advance),
            .page_size     (page_size_reg),
            .tok_in_valid  (chain_valid[g]),
            .tok_in        (chain_tok[g]),
            .tok_out_valid (chain_valid[g+1]),
            .tok_out       (chain_tok[g+1])
        );
    end

    // Result decode and output register
    ptat_result u_result (
        .clk              (clk),
        .rst_n            (rst_n),
        .page_size        (page_size_reg),
        .tok_valid        (chain_valid[ENTRY_COUNT]),
        .tok              (chain_tok[ENTRY_COUNT]),
        .advance          (advance),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .hit              (hit),
        .permitted        (permitted),
        .physical_address (physical_address)
    );

endmodule
